// ===== rtl/ring_plane_polar_projection_core_macros.svh =====
// Assertion shorthands; clk_i and rst_ni must be in scope.
`ifndef RING_PLANE_POLAR_PROJECTION_CORE_MACROS_SVH
`define RING_PLANE_POLAR_PROJECTION_CORE_MACROS_SVH

// Same-cycle implication.
`define RPPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rppc_pkg.sv =====
package rppc_pkg;

  localparam int IN_W  = 40;
  localparam int OUT_W = 41;
  localparam int LON_W = 26;
  localparam int ANG_W = 28;
  localparam int XY_W  = 58;
  localparam int Z_W   = 38;
  localparam int IDX_W = 6;

  localparam logic [31:0] GAIN_Q32 = 32'h9B74EDA8;
  localparam logic [33:0] RAD_Q24  = 34'd961263669;

  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 28'sd5898240;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 28'sd11796480;
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 28'sd23592960;
  localparam logic signed [Z_W-1:0]   Z_HALF_TURN  = 38'sd3019898880;

  typedef enum logic [2:0] {
    OP_NONE     = 3'd0,
    OP_LOAD_FWD = 3'd1,
    OP_LOAD_INV = 3'd2,
    OP_MUL_LO   = 3'd3,
    OP_MUL_HI   = 3'd4,
    OP_SETUP    = 3'd5,
    OP_ITER     = 3'd6
  } cordic_op_e;

  typedef struct packed {
    cordic_op_e op;
    logic       vector_mode;
    logic       negate;
  } cordic_ctl_t;

  typedef struct packed {
    logic last_iter;
  } cordic_sts_t;

  // atan(2^-i) in Q24 degrees
  function automatic logic signed [Z_W-1:0] atan_step(input logic [IDX_W-1:0] i);
    logic [33:0] acc;
    logic signed [Z_W-1:0] r;
    acc = RAD_Q24 + (34'd1 << (i - IDX_W'(1)));
    r = $signed(Z_W'(acc >> i));
    case (i)
      6'd0:    r = 38'sd754974720;
      6'd1:    r = 38'sd445687602;
      6'd2:    r = 38'sd235489088;
      6'd3:    r = 38'sd119537938;
      6'd4:    r = 38'sd60000934;
      6'd5:    r = 38'sd30029717;
      6'd6:    r = 38'sd15018523;
      6'd7:    r = 38'sd7509720;
      6'd8:    r = 38'sd3754917;
      6'd9:    r = 38'sd1877466;
      6'd10:   r = 38'sd938734;
      default: r = r;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ring_plane_polar_projection_core.sv =====
// channel | dir | handshake            | fields
// config  | in  | cfg_we_i             | cfg_idx_i, cfg_data_i
// request | in  | start high, busy low | kind_i, radius_in_i, longitude_in_i, x_in_i, y_in_i
// result  | out | valid_o, one cycle   | x_out_o, y_out_o, radius_out_o, longitude_out_o, good_o
//
// Steps per item, in order, from acceptance to the strobe; the next item is taken at the strobe.
// Forward: angle wrap, multiply low/high, setup, CORDIC iterations, done; negative radius: done.
// Inverse: CORDIC iterations, multiply low/high, post, angle wrap, done; origin: angle wrap, done.
// Both directions use the shared shift-add CORDIC iterations; the gain multiply uses one
// 32x32 multiplier in two passes. busy is high from acceptance until the result strobe.
// Reset clears the config registers and the stored last longitude; results are never stalled.
`include "ring_plane_polar_projection_core_macros.svh"

module ring_plane_polar_projection_core #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [rppc_pkg::LON_W-1:0]          cfg_data_i,
  input  logic                                start,
  output logic                                busy,
  input  logic                                kind_i,
  input  logic signed [rppc_pkg::IN_W-1:0]    radius_in_i,
  input  logic signed [rppc_pkg::LON_W-1:0]   longitude_in_i,
  input  logic signed [rppc_pkg::IN_W-1:0]    x_in_i,
  input  logic signed [rppc_pkg::IN_W-1:0]    y_in_i,
  output logic                                valid_o,
  output logic signed [rppc_pkg::OUT_W-1:0]   x_out_o,
  output logic signed [rppc_pkg::OUT_W-1:0]   y_out_o,
  output logic [rppc_pkg::OUT_W-1:0]          radius_out_o,
  output logic signed [rppc_pkg::LON_W-1:0]   longitude_out_o,
  output logic                                good_o
);
  import rppc_pkg::*;

  localparam logic [1:0] REG_CENTER = 2'd0;
  localparam logic [1:0] REG_CW     = 2'd1;
  localparam logic [1:0] REG_D180   = 2'd2;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_WRAP   = 8'b0000_0010,
    S_MUL_LO = 8'b0000_0100,
    S_MUL_HI = 8'b0000_1000,
    S_SETUP  = 8'b0001_0000,
    S_ITER   = 8'b0010_0000,
    S_POST   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [LON_W-1:0]        center_q;
  logic                    cw_q, d180_q;
  logic [LON_W-1:0]        last_q, last_d;
  logic                    kind_q, kind_d, bad_q, bad_d, origin_q, origin_d;
  logic signed [ANG_W-1:0] ang_q, ang_d;
  logic                    valid_q, valid_d;

  logic signed [OUT_W-1:0] x_out_q, x_out_d, y_out_q, y_out_d;
  logic [OUT_W-1:0]        rad_out_q, rad_out_d;
  logic [LON_W-1:0]        lon_out_q, lon_out_d;
  logic                    good_q, good_d;

  cordic_ctl_t             ctl;
  cordic_sts_t             sts;
  logic signed [XY_W-1:0]  cx, cy, xsum, ysum;
  logic signed [Z_W-1:0]   cz, zsum;

  logic signed [ANG_W-1:0] c_ext, lon_ext, last_ext, quad_ang, post_t, fin_ang;
  logic                    quad_neg;

  rppc_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .radius_i(radius_in_i),
    .x_i     (x_in_i),
    .y_i     (y_in_i),
    .angle_i (quad_ang),
    .x_o     (cx),
    .y_o     (cy),
    .z_o     (cz),
    .sts_o   (sts)
  );

  always_comb begin
    c_ext    = {{(ANG_W-LON_W){center_q[LON_W-1]}}, center_q};
    lon_ext  = {{(ANG_W-LON_W){longitude_in_i[LON_W-1]}}, longitude_in_i};
    last_ext = {{(ANG_W-LON_W){last_q[LON_W-1]}}, last_q};

    quad_neg = 1'b0;
    quad_ang = ang_q;
    if (ang_q > QUARTER_TURN) begin
      quad_neg = 1'b1;
      quad_ang = ang_q - HALF_TURN;
    end else if (ang_q < -QUARTER_TURN) begin
      quad_neg = 1'b1;
      quad_ang = ang_q + HALF_TURN;
    end

    zsum    = cz + Z_W'(128);
    post_t  = zsum[ANG_W+7:8];
    xsum    = cx + XY_W'(32768);
    ysum    = cy + XY_W'(32768);
    fin_ang = (d180_q && (ang_q > HALF_TURN)) ? ang_q - FULL_TURN : ang_q;
  end

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    bad_d     = bad_q;
    origin_d  = origin_q;
    ang_d     = ang_q;
    last_d    = last_q;
    valid_d   = 1'b0;
    x_out_d   = x_out_q;
    y_out_d   = y_out_q;
    rad_out_d = rad_out_q;
    lon_out_d = lon_out_q;
    good_d    = good_q;
    ctl       = '{op: OP_NONE, vector_mode: kind_q, negate: quad_neg};

    case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d   = kind_i;
          bad_d    = 1'b0;
          origin_d = 1'b0;
          if (!kind_i) begin
            ctl.op  = OP_LOAD_FWD;
            ang_d   = cw_q ? c_ext - lon_ext : lon_ext - c_ext;
            last_d  = longitude_in_i;
            if (radius_in_i[IN_W-1]) begin
              bad_d   = 1'b1;
              state_d = S_DONE;
            end else begin
              state_d = S_WRAP;
            end
          end else begin
            ctl.op = OP_LOAD_INV;
            if (x_in_i == '0 && y_in_i == '0) begin
              origin_d = 1'b1;
              ang_d    = last_ext;
              state_d  = S_WRAP;
            end else begin
              state_d = S_ITER;
            end
          end
        end
      end
      S_WRAP: begin
        if (!kind_q) begin
          if (ang_q >= HALF_TURN) begin
            ang_d = ang_q - FULL_TURN;
          end else if (ang_q < -HALF_TURN) begin
            ang_d = ang_q + FULL_TURN;
          end else begin
            state_d = S_MUL_LO;
          end
        end else begin
          if (ang_q >= FULL_TURN) begin
            ang_d = ang_q - FULL_TURN;
          end else if (ang_q < 0) begin
            ang_d = ang_q + FULL_TURN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_MUL_LO: begin
        ctl.op  = OP_MUL_LO;
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        ctl.op  = OP_MUL_HI;
        state_d = kind_q ? S_POST : S_SETUP;
      end
      S_SETUP: begin
        ctl.op  = OP_SETUP;
        state_d = S_ITER;
      end
      S_ITER: begin
        ctl.op = OP_ITER;
        if (sts.last_iter) begin
          state_d = kind_q ? S_MUL_LO : S_DONE;
        end
      end
      S_POST: begin
        ang_d   = cw_q ? c_ext - post_t : c_ext + post_t;
        state_d = S_WRAP;
      end
      S_DONE: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
        if (!kind_q) begin
          good_d    = !bad_q;
          x_out_d   = bad_q ? '0 : xsum[OUT_W+15:16];
          y_out_d   = bad_q ? '0 : ysum[OUT_W+15:16];
          rad_out_d = '0;
          lon_out_d = '0;
        end else begin
          good_d    = 1'b1;
          x_out_d   = '0;
          y_out_d   = '0;
          rad_out_d = origin_q ? '0 : xsum[OUT_W+15:16];
          lon_out_d = fin_ang[LON_W-1:0];
          last_d    = fin_ang[LON_W-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      valid_q  <= 1'b0;
      center_q <= '0;
      cw_q     <= 1'b0;
      d180_q   <= 1'b0;
      last_q   <= '0;
      kind_q   <= 1'b0;
      bad_q    <= 1'b0;
      origin_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      last_q   <= last_d;
      kind_q   <= kind_d;
      bad_q    <= bad_d;
      origin_q <= origin_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_CENTER: center_q <= cfg_data_i;
          REG_CW:     cw_q     <= cfg_data_i[0];
          REG_D180:   d180_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ang_q     <= ang_d;
    x_out_q   <= x_out_d;
    y_out_q   <= y_out_d;
    rad_out_q <= rad_out_d;
    lon_out_q <= lon_out_d;
    good_q    <= good_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign valid_o         = valid_q;
  assign x_out_o         = x_out_q;
  assign y_out_o         = y_out_q;
  assign radius_out_o    = rad_out_q;
  assign longitude_out_o = lon_out_q;
  assign good_o          = good_q;

  `RPPC_ASSERT_IMPL(a_strobe_not_busy, valid_o, !busy, "result strobe while busy")
  `RPPC_ASSERT_NEXT(a_done_strobes, state_q == S_DONE, valid_o, "finished item gave no strobe")
  `RPPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start")
  `RPPC_ASSERT_IMPL(a_bad_zero, valid_o && !good_o,
                    x_out_o == '0 && y_out_o == '0 && radius_out_o == '0 && longitude_out_o == '0,
                    "failed item has nonzero fields")

endmodule

// ===== rtl/rppc_cordic.sv =====
module rppc_cordic #(
  parameter int CORDIC_ITERATIONS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  rppc_pkg::cordic_ctl_t                  ctl_i,
  input  logic signed [rppc_pkg::IN_W-1:0]       radius_i,
  input  logic signed [rppc_pkg::IN_W-1:0]       x_i,
  input  logic signed [rppc_pkg::IN_W-1:0]       y_i,
  input  logic signed [rppc_pkg::ANG_W-1:0]      angle_i,
  output logic signed [rppc_pkg::XY_W-1:0]       x_o,
  output logic signed [rppc_pkg::XY_W-1:0]       y_o,
  output logic signed [rppc_pkg::Z_W-1:0]        z_o,
  output rppc_pkg::cordic_sts_t                  sts_o
);
  import rppc_pkg::*;

  localparam int CntW = $clog2(CORDIC_ITERATIONS);

  logic signed [XY_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]  z_q, z_d;
  logic [63:0]            m_q, m_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic signed [XY_W-1:0] xs, ys, x_ld, y_ld, r_ld;
  logic signed [Z_W-1:0]  at;
  logic                   rot_pos;
  logic [31:0]            mul_a;
  logic [63:0]            prod;

  always_comb begin
    xs      = x_q >>> cnt_q;
    ys      = y_q >>> cnt_q;
    at      = atan_step(IDX_W'(cnt_q));
    rot_pos = ctl_i.vector_mode ? y_q[XY_W-1] : ~z_q[Z_W-1];
    x_ld    = {{(XY_W-IN_W-16){x_i[IN_W-1]}}, x_i, 16'h0000};
    y_ld    = {{(XY_W-IN_W-16){y_i[IN_W-1]}}, y_i, 16'h0000};
    r_ld    = {{(XY_W-IN_W-16){radius_i[IN_W-1]}}, radius_i, 16'h0000};
    mul_a   = (ctl_i.op == OP_MUL_LO) ? x_q[31:0] : 32'(x_q[XY_W-1:32]);
    prod    = 64'(mul_a) * 64'(GAIN_Q32);

    x_d   = x_q;
    y_d   = y_q;
    z_d   = z_q;
    m_d   = m_q;
    cnt_d = cnt_q;
    case (ctl_i.op)
      OP_LOAD_FWD: begin
        x_d = r_ld;
      end
      OP_LOAD_INV: begin
        cnt_d = '0;
        if (x_i[IN_W-1]) begin
          x_d = -x_ld;
          y_d = -y_ld;
          z_d = Z_HALF_TURN;
        end else begin
          x_d = x_ld;
          y_d = y_ld;
          z_d = '0;
        end
      end
      OP_MUL_LO: begin
        m_d = prod;
      end
      OP_MUL_HI: begin
        x_d = $signed(XY_W'(prod + (m_q >> 32)));
      end
      OP_SETUP: begin
        cnt_d = '0;
        x_d   = ctl_i.negate ? -x_q : x_q;
        y_d   = '0;
        z_d   = {{(Z_W-ANG_W-8){angle_i[ANG_W-1]}}, angle_i, 8'h00};
      end
      OP_ITER: begin
        cnt_d = cnt_q + CntW'(1);
        if (rot_pos) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
    m_q <= m_d;
  end

  assign x_o             = x_q;
  assign y_o             = y_q;
  assign z_o             = z_q;
  assign sts_o.last_iter = (cnt_q == CntW'(CORDIC_ITERATIONS - 1));

endmodule
